// ===== hdl/timer_interrupt_controller_macros.svh =====
// Assertion macros for the timer and interrupt controller.
// The macros pick up clk and rst_n from the module that uses them.
`ifndef TIMER_INTERRUPT_CONTROLLER_MACROS_SVH
`define TIMER_INTERRUPT_CONTROLLER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define TIC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define TIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TIC_ASSERT_IMPL(lbl, ante, cons, msg)
`define TIC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/tic_pkg.sv =====
package tic_pkg;

    localparam int OP_W   = 3;
    localparam int BYTE_W = 8;
    localparam int MASK_W = 5;
    localparam int VEC_W  = 7;

    localparam int DEFAULT_CYCLE_SCALE = 4;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_READ    = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE   = 3'd2;
    localparam logic [OP_W-1:0] OP_RAISE   = 3'd3;
    localparam logic [OP_W-1:0] OP_SERVICE = 3'd4;

    // Register addresses
    localparam logic [BYTE_W-1:0] ADDR_DIV  = 8'h04;
    localparam logic [BYTE_W-1:0] ADDR_TIMA = 8'h05;
    localparam logic [BYTE_W-1:0] ADDR_TMA  = 8'h06;
    localparam logic [BYTE_W-1:0] ADDR_TAC  = 8'h07;
    localparam logic [BYTE_W-1:0] ADDR_IF   = 8'h0F;
    localparam logic [BYTE_W-1:0] ADDR_IE   = 8'hFF;

    localparam logic [BYTE_W-1:0] UNMAPPED_RDATA = 8'hFF;

    // Reset values
    localparam logic [BYTE_W-1:0] DIV_RESET = 8'hAB;
    localparam logic [BYTE_W-1:0] TAC_RESET = 8'hF8;
    localparam logic [BYTE_W-1:0] IF_RESET  = 8'hE1;

    localparam int TAC_RUN_BIT = 2;
    localparam int TIMER_IRQ   = 2;

    localparam logic [VEC_W-1:0] VECTOR_BASE = 7'h40;

    localparam int DIV_UNITS      = 64;
    localparam int TIMER_UNITS_MAX = 256;

    // Timer input clock select, in cycle units before scaling
    function automatic logic [8:0] tic_rate(input logic [1:0] sel);
        logic [8:0] units;
        unique case (sel)
            2'd0: units = 9'd256;
            2'd1: units = 9'd4;
            2'd2: units = 9'd16;
            2'd3: units = 9'd64;
        endcase
        return units;
    endfunction

endpackage

// ===== hdl/timer_interrupt_controller.sv =====
// Divider, timer and interrupt controller.
// Input channel (in_valid / in_stall) carries one operation per transfer: tick,
// register read, register write, interrupt raise or interrupt service. Output
// channel (out_valid / out_stall) returns exactly one result per input item.
// A non-tick item goes from the input transfer to the closing state, where its
// result is loaded into the output register and the input reopens.
// A tick runs one shared compare/subtract unit under a small sequencer: one
// divider step per cycle until the compare fails, then, when the timer runs,
// one counter step per cycle until the compare fails, then the closing state.
// One item is in work at a time; in_stall stays high from the transfer until
// the result is loaded into the output register. A new item is taken while a
// finished result still sits in the output register. When the receiver
// stalls, the output register holds and the sequencer waits in its closing
// state. Reset (rst_n low, async) empties the output register and loads DIV
// 0xAB, TAC 0xF8, IF 0xE1 and zeros in TIMA, TMA, IE and the accumulators; the
// timer period holds no value until TAC is written, and the result and output
// data registers hold none until first loaded.
`include "timer_interrupt_controller_macros.svh"

module timer_interrupt_controller #(
    parameter int CYCLE_SCALE = tic_pkg::DEFAULT_CYCLE_SCALE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tic_pkg::OP_W-1:0]    op,
    input  logic [tic_pkg::BYTE_W-1:0]  cycles,
    input  logic [tic_pkg::BYTE_W-1:0]  reg_addr,
    input  logic [tic_pkg::BYTE_W-1:0]  wdata,
    input  logic [tic_pkg::MASK_W-1:0]  raise_mask,
    input  logic                        master_enable,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [tic_pkg::BYTE_W-1:0]  rdata,
    output logic                        taken,
    output logic [tic_pkg::VEC_W-1:0]   vector,
    output logic                        wake
);
    import tic_pkg::*;

    localparam int DivPeriod  = DIV_UNITS * CYCLE_SCALE;
    localparam int PeriodMax  = TIMER_UNITS_MAX * CYCLE_SCALE;
    localparam int DIV_ACC_W  = $clog2(DivPeriod + 256);
    localparam int PER_W      = $clog2(PeriodMax + 1);
    localparam int TMR_ACC_W  = $clog2(PeriodMax + 256);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_TMR  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [BYTE_W-1:0]     div_reg, div_next;
    logic [DIV_ACC_W-1:0]  div_acc_reg, div_acc_next;
    logic [BYTE_W-1:0]     cnt_reg, cnt_next;
    logic [BYTE_W-1:0]     tma_reg, tma_next;
    logic [BYTE_W-1:0]     tac_reg, tac_next;
    logic [TMR_ACC_W-1:0]  tmr_acc_reg, tmr_acc_next;
    logic [PER_W-1:0]      tmr_period_reg, tmr_period_next;
    logic [BYTE_W-1:0]     if_reg, if_next;
    logic [BYTE_W-1:0]     ie_reg, ie_next;
    logic [BYTE_W-1:0]     units_reg, units_next;
    logic [BYTE_W-1:0]     res_rdata_reg, res_rdata_next;
    logic                  res_taken_reg, res_taken_next;
    logic [VEC_W-1:0]      res_vector_reg, res_vector_next;
    logic                  res_wake_reg, res_wake_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]     rdata_reg, rdata_next;
    logic                  taken_reg, taken_next;
    logic [VEC_W-1:0]      vector_reg, vector_next;
    logic                  wake_reg, wake_next;

    // Shared compare/subtract unit
    logic                  unit_tmr;
    logic [TMR_ACC_W-1:0]  unit_a;
    logic [TMR_ACC_W-1:0]  unit_b;
    logic [TMR_ACC_W:0]    unit_diff;
    logic                  unit_ge;

    logic                  accept;
    logic                  out_free;
    logic [MASK_W-1:0]     pending;
    logic [2:0]            irq_sel;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    assign unit_tmr  = (state_reg == S_TMR);
    assign unit_a    = unit_tmr ? tmr_acc_reg : TMR_ACC_W'(div_acc_reg);
    assign unit_b    = unit_tmr ? TMR_ACC_W'(tmr_period_reg) : TMR_ACC_W'(DivPeriod);
    assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge   = !unit_diff[TMR_ACC_W];

    assign pending = ie_reg[MASK_W-1:0] & if_reg[MASK_W-1:0];

    // Lowest pending source wins
    always_comb
    begin
        irq_sel = 3'd0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (pending[i])
            begin
                irq_sel = 3'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        div_next        = div_reg;
        div_acc_next    = div_acc_reg;
        cnt_next        = cnt_reg;
        tma_next        = tma_reg;
        tac_next        = tac_reg;
        tmr_acc_next    = tmr_acc_reg;
        tmr_period_next = tmr_period_reg;
        if_next         = if_reg;
        ie_next         = ie_reg;
        units_next      = units_reg;
        res_rdata_next  = res_rdata_reg;
        res_taken_next  = res_taken_reg;
        res_vector_next = res_vector_reg;
        res_wake_next   = res_wake_reg;
        out_valid_next  = out_valid_reg && out_stall;
        rdata_next      = rdata_reg;
        taken_next      = taken_reg;
        vector_next     = vector_reg;
        wake_next       = wake_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_rdata_next  = '0;
                    res_taken_next  = 1'b0;
                    res_vector_next = '0;
                    res_wake_next   = 1'b0;
                    state_next      = S_DONE;
                    unique case (op)
                        OP_TICK:
                        begin
                            units_next   = cycles;
                            div_acc_next = div_acc_reg + DIV_ACC_W'(cycles);
                            state_next   = S_DIV;
                        end
                        OP_READ:
                        begin
                            unique case (reg_addr)
                                ADDR_DIV:  res_rdata_next = div_reg;
                                ADDR_TIMA: res_rdata_next = cnt_reg;
                                ADDR_TMA:  res_rdata_next = tma_reg;
                                ADDR_TAC:  res_rdata_next = tac_reg;
                                ADDR_IF:   res_rdata_next = if_reg;
                                ADDR_IE:   res_rdata_next = ie_reg;
                                default:   res_rdata_next = UNMAPPED_RDATA;
                            endcase
                        end
                        OP_WRITE:
                        begin
                            unique case (reg_addr)
                                ADDR_DIV:  div_next = '0;
                                ADDR_TIMA: cnt_next = wdata;
                                ADDR_TMA:  tma_next = wdata;
                                ADDR_TAC:
                                begin
                                    tac_next        = wdata;
                                    tmr_period_next =
                                        PER_W'(32'(tic_rate(wdata[1:0])) * CYCLE_SCALE);
                                end
                                ADDR_IF:   if_next  = wdata;
                                ADDR_IE:   ie_next  = wdata;
                                default:   ;
                            endcase
                        end
                        OP_RAISE:
                        begin
                            if_next       = if_reg | BYTE_W'(raise_mask);
                            res_wake_next = |(ie_reg[MASK_W-1:0] & raise_mask);
                        end
                        OP_SERVICE:
                        begin
                            if (master_enable && (pending != '0))
                            begin
                                if_next[irq_sel] = 1'b0;
                                res_taken_next   = 1'b1;
                                res_vector_next  = VECTOR_BASE + VEC_W'({irq_sel, 3'b000});
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                if (unit_ge)
                begin
                    div_acc_next = unit_diff[DIV_ACC_W-1:0];
                    div_next     = div_reg + 8'd1;
                end
                else if (tac_reg[TAC_RUN_BIT])
                begin
                    tmr_acc_next = tmr_acc_reg + TMR_ACC_W'(units_reg);
                    state_next   = S_TMR;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_TMR:
            begin
                if (unit_ge)
                begin
                    tmr_acc_next = unit_diff[TMR_ACC_W-1:0];
                    if (cnt_reg == 8'hFF)
                    begin
                        // Wrap: reload and raise the timer flag
                        cnt_next              = tma_reg;
                        if_next[TIMER_IRQ]    = 1'b1;
                        res_wake_next         = res_wake_reg | ie_reg[TIMER_IRQ];
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 8'd1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    rdata_next     = res_rdata_reg;
                    taken_next     = res_taken_reg;
                    vector_next    = res_vector_reg;
                    wake_next      = res_wake_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_reg       <= DIV_RESET;
            div_acc_reg   <= '0;
            cnt_reg       <= '0;
            tma_reg       <= '0;
            tac_reg       <= TAC_RESET;
            tmr_acc_reg   <= '0;
            if_reg        <= IF_RESET;
            ie_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_reg       <= div_next;
            div_acc_reg   <= div_acc_next;
            cnt_reg       <= cnt_next;
            tma_reg       <= tma_next;
            tac_reg       <= tac_next;
            tmr_acc_reg   <= tmr_acc_next;
            if_reg        <= if_next;
            ie_reg        <= ie_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmr_period_reg <= tmr_period_next;
        units_reg      <= units_next;
        res_rdata_reg  <= res_rdata_next;
        res_taken_reg  <= res_taken_next;
        res_vector_reg <= res_vector_next;
        res_wake_reg   <= res_wake_next;
        rdata_reg      <= rdata_next;
        taken_reg      <= taken_next;
        vector_reg     <= vector_next;
        wake_reg       <= wake_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign rdata     = rdata_reg;
    assign taken     = taken_reg;
    assign vector    = vector_reg;
    assign wake      = wake_reg;

    `TIC_ASSERT_NEXT(a_non_tick_done, accept && (op != OP_TICK), state_reg == S_DONE, "non-tick item did not go straight to completion")
    `TIC_ASSERT_IMPL(a_timer_running, state_reg == S_TMR, tac_reg[TAC_RUN_BIT], "timer loop active while timer stopped")
    `TIC_ASSERT_IMPL(a_div_acc_bound, state_reg != S_DIV, div_acc_reg < DIV_ACC_W'(DivPeriod), "divider accumulator left at or above its period")
    `TIC_ASSERT_IMPL(a_vector_taken, out_valid_reg, taken_reg == (vector_reg != '0), "vector and taken disagree")

endmodule

// ===== dv/timer_interrupt_controller_tb.sv =====
`timescale 1ns / 100ps

module timer_interrupt_controller_tb;

    import tic_pkg::*;

    localparam int SCALE      = DEFAULT_CYCLE_SCALE;
    localparam int DIV_SPAN   = DIV_UNITS * SCALE;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 300;

    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_SERVICE + OP_W'(1);
    localparam logic [OP_W-1:0] OP_LAST         = '1;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] cycles;
        logic [BYTE_W-1:0] reg_addr;
        logic [BYTE_W-1:0] wdata;
        logic [MASK_W-1:0] raise_mask;
        logic              master_enable;
        bit                hold;
    } tic_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rdata;
        logic              taken;
        logic [VEC_W-1:0]  vector;
        logic              wake;
    } tic_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [OP_W-1:0]   op = '0;
    logic [BYTE_W-1:0] cycles = '0;
    logic [BYTE_W-1:0] reg_addr = '0;
    logic [BYTE_W-1:0] wdata = '0;
    logic [MASK_W-1:0] raise_mask = '0;
    logic              master_enable = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [BYTE_W-1:0] rdata;
    logic              taken;
    logic [VEC_W-1:0]  vector;
    logic              wake;

    timer_interrupt_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .cycles        (cycles),
        .reg_addr      (reg_addr),
        .wdata         (wdata),
        .raise_mask    (raise_mask),
        .master_enable (master_enable),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .rdata         (rdata),
        .taken         (taken),
        .vector        (vector),
        .wake          (wake)
    );

    // Mirror of the block's registers
    logic [BYTE_W-1:0] div_reg   = DIV_RESET;
    int unsigned       div_frac  = 0;
    logic [BYTE_W-1:0] tima_reg  = '0;
    logic [BYTE_W-1:0] tma_reg   = '0;
    logic [BYTE_W-1:0] tac_reg   = TAC_RESET;
    int unsigned       tima_frac = 0;
    int unsigned       tima_span = 0;
    logic [BYTE_W-1:0] if_reg    = IF_RESET;
    logic [BYTE_W-1:0] ie_reg    = '0;

    tic_item_t   op_backlog[$];
    tic_result_t due_results[$];
    tic_item_t   cur_item;

    int tx_gap_max   = 0;
    int rx_stall_max = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    int sent_cnt     = 0;
    int got_cnt      = 0;
    int err_cnt      = 0;
    int cycle_cnt    = 0;

    function automatic logic raise_irq(logic [BYTE_W-1:0] bits);
        if_reg = if_reg | bits;
        return (ie_reg & bits) != '0;
    endfunction

    function automatic tic_result_t timer_irq_step(tic_item_t it);
        tic_result_t res;
        int unsigned acc;
        logic [MASK_W-1:0] pend;
        res = '0;
        case (it.op)
            OP_TICK: begin
                acc = div_frac + it.cycles;
                while (acc >= DIV_SPAN) begin
                    div_reg = div_reg + 1'b1;
                    acc -= DIV_SPAN;
                end
                div_frac = acc;
                if (tac_reg[TAC_RUN_BIT] && tima_span != 0) begin
                    acc = tima_frac + it.cycles;
                    while (acc >= tima_span) begin
                        tima_reg = tima_reg + 1'b1;
                        // wrap: reload from modulo and flag the timer
                        if (tima_reg == '0) begin
                            tima_reg = tma_reg;
                            if (raise_irq(BYTE_W'(1) << TIMER_IRQ))
                                res.wake = 1'b1;
                        end
                        acc -= tima_span;
                    end
                    tima_frac = acc;
                end
            end
            OP_READ: begin
                case (it.reg_addr)
                    ADDR_DIV:  res.rdata = div_reg;
                    ADDR_TIMA: res.rdata = tima_reg;
                    ADDR_TMA:  res.rdata = tma_reg;
                    ADDR_TAC:  res.rdata = tac_reg;
                    ADDR_IF:   res.rdata = if_reg;
                    ADDR_IE:   res.rdata = ie_reg;
                    default:   res.rdata = UNMAPPED_RDATA;
                endcase
            end
            OP_WRITE: begin
                case (it.reg_addr)
                    ADDR_DIV:  div_reg = '0;
                    ADDR_TIMA: tima_reg = it.wdata;
                    ADDR_TMA:  tma_reg = it.wdata;
                    ADDR_TAC: begin
                        tac_reg = it.wdata;
                        case (it.wdata[1:0])
                            2'd0: tima_span = 256 * SCALE;
                            2'd1: tima_span = 4 * SCALE;
                            2'd2: tima_span = 16 * SCALE;
                            default: tima_span = 64 * SCALE;
                        endcase
                    end
                    ADDR_IF:   if_reg = it.wdata;
                    ADDR_IE:   ie_reg = it.wdata;
                    default: ;
                endcase
            end
            OP_RAISE: res.wake = raise_irq(BYTE_W'(it.raise_mask));
            OP_SERVICE: begin
                pend = ie_reg[MASK_W-1:0] & if_reg[MASK_W-1:0];
                if (it.master_enable) begin
                    // lowest pending enabled flag wins
                    for (int i = 0; i < MASK_W; i++) begin
                        if (pend[i] && !res.taken) begin
                            if_reg[i] = 1'b0;
                            res.taken = 1'b1;
                            res.vector = VECTOR_BASE + VEC_W'(8 * i);
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic push_item(logic [OP_W-1:0] code, logic [BYTE_W-1:0] units,
                             logic [BYTE_W-1:0] addr, logic [BYTE_W-1:0] data,
                             logic [MASK_W-1:0] mask, logic me);
        tic_item_t it;
        it.op = code;
        it.cycles = units;
        it.reg_addr = addr;
        it.wdata = data;
        it.raise_mask = mask;
        it.master_enable = me;
        it.hold = 1'b0;
        op_backlog.push_back(it);
    endtask

    function automatic tic_item_t random_item();
        tic_item_t it;
        int pick;
        it.cycles = BYTE_W'($urandom);
        it.reg_addr = BYTE_W'($urandom);
        it.wdata = BYTE_W'($urandom);
        it.raise_mask = MASK_W'($urandom);
        it.master_enable = ($urandom_range(0, 3) != 0);
        it.hold = ($urandom_range(0, 99) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            it.op = OP_TICK;
        else if (pick < 55)
            it.op = OP_READ;
        else if (pick < 75)
            it.op = OP_WRITE;
        else if (pick < 85)
            it.op = OP_RAISE;
        else if (pick < 97)
            it.op = OP_SERVICE;
        else
            it.op = OP_W'($urandom_range(OP_FIRST_UNUSED, OP_LAST));
        if ((it.op == OP_READ || it.op == OP_WRITE) && $urandom_range(0, 7) != 0) begin
            case ($urandom_range(0, 5))
                0: it.reg_addr = ADDR_DIV;
                1: it.reg_addr = ADDR_TIMA;
                2: it.reg_addr = ADDR_TMA;
                3: it.reg_addr = ADDR_TAC;
                4: it.reg_addr = ADDR_IF;
                default: it.reg_addr = ADDR_IE;
            endcase
        end
        // steer writes toward a running timer close to wrapping
        if (it.op == OP_WRITE && it.reg_addr == ADDR_TIMA && $urandom_range(0, 1))
            it.wdata[7:4] = 4'hF;
        if (it.op == OP_WRITE && it.reg_addr == ADDR_TAC && $urandom_range(0, 3) != 0)
            it.wdata[TAC_RUN_BIT] = 1'b1;
        return it;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endtask

    initial begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Input side: present backlog items, hold while stalled
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            sent_cnt <= 0;
        end
        else if (!(in_valid && in_stall)) begin
            if (in_valid) begin
                due_results.push_back(timer_irq_step(cur_item));
                sent_cnt <= sent_cnt + 1;
            end
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (op_backlog.size() != 0 &&
                     !(op_backlog[0].hold && sent_cnt + int'(in_valid) != got_cnt)) begin
                cur_item      <= op_backlog[0];
                op            <= op_backlog[0].op;
                cycles        <= op_backlog[0].cycles;
                reg_addr      <= op_backlog[0].reg_addr;
                wdata         <= op_backlog[0].wdata;
                raise_mask    <= op_backlog[0].raise_mask;
                master_enable <= op_backlog[0].master_enable;
                in_valid      <= 1'b1;
                gap_left      <= $urandom_range(0, tx_gap_max);
                void'(op_backlog.pop_front());
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output side: check each transfer, then stall for a drawn number of cycles
    always @(posedge clk or negedge rst_n) begin : result_side
        tic_result_t want;
        int n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            got_cnt    <= 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                got_cnt <= got_cnt + 1;
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual rdata %0d",
                             $time, rdata);
                    err_cnt++;
                end
                else begin
                    want = due_results.pop_front();
                    check_field("rdata", want.rdata, rdata);
                    check_field("taken", want.taken, taken);
                    check_field("vector", want.vector, vector);
                    check_field("wake", want.wake, wake);
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                out_stall  <= (stall_left > 1);
            end
            else if (out_valid && !out_stall) begin
                n = $urandom_range(0, rx_stall_max);
                stall_left <= n;
                out_stall  <= (n != 0);
            end
        end
    end

    initial begin
        tic_item_t it;
        tx_gap_max = 2;
        rx_stall_max = 2;

        push_item(OP_READ, 8'd0, ADDR_DIV, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_TIMA, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_TMA, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_TAC, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_IF, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_IE, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, 8'h00, 8'h00, '0, 1'b0);
        push_item(OP_WRITE, 8'd0, ADDR_IE, 8'h1F, '0, 1'b0);
        push_item(OP_WRITE, 8'd0, ADDR_TMA, 8'hFF, '0, 1'b0);
        push_item(OP_WRITE, 8'd0, ADDR_TIMA, 8'hF2, '0, 1'b0);
        push_item(OP_WRITE, 8'd0, ADDR_TAC, 8'h05, '0, 1'b0);
        // fastest rate, full tick: counter wraps twice
        push_item(OP_TICK, 8'hFF, 8'h00, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_TIMA, 8'h00, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_IF, 8'h00, '0, 1'b0);
        push_item(OP_SERVICE, 8'd0, 8'h00, 8'h00, '0, 1'b0);
        push_item(OP_SERVICE, 8'd0, 8'h00, 8'h00, '0, 1'b1);
        push_item(OP_SERVICE, 8'd0, 8'h00, 8'h00, '0, 1'b1);
        push_item(OP_RAISE, 8'd0, 8'h00, 8'h00, '1, 1'b0);
        push_item(OP_SERVICE, 8'd0, 8'h00, 8'h00, '0, 1'b1);
        push_item(OP_WRITE, 8'd0, ADDR_DIV, 8'h5A, '0, 1'b0);
        push_item(OP_READ, 8'd0, ADDR_DIV, 8'h00, '0, 1'b0);
        push_item(OP_WRITE, 8'd0, 8'h80, 8'hFF, '0, 1'b0);
        push_item(OP_READ, 8'd0, 8'hFE, 8'h00, '0, 1'b0);
        push_item(OP_FIRST_UNUSED, 8'hFF, ADDR_IF, 8'hFF, '1, 1'b1);
        push_item(OP_LAST, 8'h00, ADDR_TIMA, 8'h00, '1, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            while (op_backlog.size() != 0)
                @(posedge clk);
            tx_gap_max   = (phase == 0 || phase == 2) ? 3 : 0;
            rx_stall_max = (phase == 0 || phase == 3) ? 3 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                it = random_item();
                // let everything drain before the first item of later phases
                if (k == 0 && phase >= 2)
                    it.hold = 1'b1;
                op_backlog.push_back(it);
            end
        end

        while (op_backlog.size() != 0 || in_valid || got_cnt != sent_cnt)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        while (due_results.size() != 0) begin
            it.op = OP_TICK;
            $display("%0t: missing result: expected rdata %0d, actual none",
                     $time, due_results[0].rdata);
            void'(due_results.pop_front());
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
